// File: sv/pip_pkg.sv
// Shared types, widths and the edge crossing check for the point in polygon tester.
package pip_pkg;

	// Polygon store size and counter widths.
	localparam int MAX_VERTICES = 16;
	localparam int MIN_VERTICES = 3;
	localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

	// Coordinate and arithmetic widths.
	localparam int LAT_W  = 30;
	localparam int LON_W  = 31;
	localparam int DY_W   = LAT_W + 1;
	localparam int DX_W   = LON_W + 1;
	localparam int PROD_W = DX_W + DY_W;

	// Operation codes of an input beat.
	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_TEST   = 1'b1;

	// Test token that travels down the row of cells, one cell per cycle.
	// It carries the point, the vertex of the previous cell, the registered
	// products of the edge just formed and the running crossing parity.
	typedef struct packed {
		logic                     valid;
		logic signed [LAT_W-1:0]  plat;
		logic signed [LON_W-1:0]  plon;
		logic signed [LAT_W-1:0]  prev_lat;
		logic signed [LON_W-1:0]  prev_lon;
		logic                     strad;
		logic                     flip;
		logic signed [PROD_W-1:0] lhs;
		logic signed [PROD_W-1:0] rhs;
		logic                     parity;
	} tok_t;

	// Per-cell control from the top level.
	typedef struct packed {
		logic wr_en;
		logic used;
	} cell_ctl_t;

	// An edge crosses when it straddles the point's latitude and the point lies
	// left of the intersection; the compare sense flips for a negative dy.
	function automatic logic edge_cross(input tok_t t);
		logic lt;
		logic gt;
		lt = (t.lhs < t.rhs);
		gt = (t.lhs > t.rhs);
		return t.strad && (t.flip ? gt : lt);
	endfunction

endpackage

// File: sv/pip_cell.sv
// One cell of the vertex row: holds one vertex and evaluates one polygon edge.
module pip_cell import pip_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cell_ctl_t               ctl,
	input  logic signed [LAT_W-1:0] wr_lat,
	input  logic signed [LON_W-1:0] wr_lon,
	input  tok_t                    tok_in,
	output tok_t                    tok_out
);

	logic signed [LAT_W-1:0]  lat_q;
	logic signed [LON_W-1:0]  lon_q;
	tok_t                     tok_q;
	tok_t                     tok_nxt;
	logic signed [DY_W-1:0]   dy;
	logic signed [DY_W-1:0]   dpy;
	logic signed [DX_W-1:0]   dpx;
	logic signed [DX_W-1:0]   dxe;
	logic signed [PROD_W-1:0] lhs;
	logic signed [PROD_W-1:0] rhs;
	logic                     straddle;

	// Vertex storage, written on an append beat addressed to this cell.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			lat_q <= wr_lat;
			lon_q <= wr_lon;
		end
	end

	// Edge from the previous vertex to this one, with the point's offsets.
	assign dy  = DY_W'(tok_in.prev_lat) - DY_W'(lat_q);
	assign dpy = DY_W'(tok_in.plat) - DY_W'(lat_q);
	assign dpx = DX_W'(tok_in.plon) - DX_W'(lon_q);
	assign dxe = DX_W'(tok_in.prev_lon) - DX_W'(lon_q);
	assign straddle = (lat_q > tok_in.plat) != (tok_in.prev_lat > tok_in.plat);

	// Cross products; their compare is done one cell further down.
	assign lhs = dpx * dy;
	assign rhs = dxe * dpy;

	// Next token: fold in the previous edge, launch this edge's products.
	always_comb begin
		tok_nxt          = tok_in;
		tok_nxt.parity   = tok_in.parity ^ (tok_in.valid && edge_cross(tok_in));
		tok_nxt.strad    = ctl.used && straddle;
		tok_nxt.flip     = dy[DY_W-1];
		tok_nxt.lhs      = lhs;
		tok_nxt.rhs      = rhs;
		if (ctl.used) begin
			tok_nxt.prev_lat = lat_q;
			tok_nxt.prev_lon = lon_q;
		end
	end

	// Hand the token to the next cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

// File: sv/point_in_polygon_test_top.sv
// Top level of the point in polygon tester: vertex row, append control and result stage.
// An append beat gives no result.
// A test beat gives its result once the test token has walked the whole row of vertex cells,
// one cell per cycle, and passed a final compare in the result stage.
// busy drops with the result strobe, so no new beat is taken until a test has its result.
// Reset clears the vertex count, the overflow flag and all tokens; vertex cells are not cleared.
module point_in_polygon_test_top import pip_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic                    operation,
	input  logic                    start_new,
	input  logic signed [LAT_W-1:0] lat,
	input  logic signed [LON_W-1:0] lon,
	output logic                    done,
	output logic                    inside_res,
	output logic                    too_few_vertices,
	output logic                    vertices_dropped
);

	logic                    busy_q;
	logic [CNT_W-1:0]        count_q;
	logic                    ovf_q;
	logic signed [LAT_W-1:0] last_lat_q;
	logic signed [LON_W-1:0] last_lon_q;
	tok_t                    tok0_q;
	tok_t                    tok [0:MAX_VERTICES];
	cell_ctl_t               ctl [0:MAX_VERTICES-1];
	logic [MAX_VERTICES:0]   tok_vld;
	logic                    accept;
	logic                    app;
	logic                    tst;
	logic                    full;
	logic                    store_en;
	logic [CNT_W-1:0]        wr_idx;
	logic                    done_q;
	logic                    inside_q;
	logic                    few_q;
	logic                    drop_q;
	logic                    few;

	// Beat decode.
	assign accept   = start && !busy_q;
	assign app      = accept && (operation == OP_APPEND);
	assign tst      = accept && (operation == OP_TEST);
	assign full     = (count_q == CNT_W'(MAX_VERTICES));
	assign store_en = app && (start_new || !full);
	assign wr_idx   = start_new ? '0 : count_q;
	assign few      = (count_q < CNT_W'(MIN_VERTICES));

	// Vertex count and overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (app) begin
			if (store_en) begin
				count_q <= wr_idx + CNT_W'(1);
			end
			if (start_new) begin
				ovf_q <= 1'b0;
			end else if (full) begin
				ovf_q <= 1'b1;
			end
		end
	end

	// Last stored vertex closes the polygon at the first cell.
	always_ff @(posedge clk) begin
		if (store_en) begin
			last_lat_q <= lat;
			last_lon_q <= lon;
		end
	end

	// Launch a test token into the head of the row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok0_q <= '0;
		end else begin
			tok0_q.valid <= tst;
			if (tst) begin
				tok0_q.plat     <= lat;
				tok0_q.plon     <= lon;
				tok0_q.prev_lat <= last_lat_q;
				tok0_q.prev_lon <= last_lon_q;
				tok0_q.strad    <= 1'b0;
				tok0_q.flip     <= 1'b0;
				tok0_q.lhs      <= '0;
				tok0_q.rhs      <= '0;
				tok0_q.parity   <= 1'b0;
			end
		end
	end

	assign tok[0] = tok0_q;

	// Row of vertex cells.
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
		assign ctl[k].wr_en = store_en && (wr_idx == CNT_W'(k));
		assign ctl[k].used  = (CNT_W'(k) < count_q);

		pip_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[k]),
			.wr_lat  (lat),
			.wr_lon  (lon),
			.tok_in  (tok[k]),
			.tok_out (tok[k+1])
		);
	end

	for (genvar k = 0; k <= MAX_VERTICES; k++) begin : g_vld
		assign tok_vld[k] = tok[k].valid;
	end

	// Busy from test acceptance until the result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (tst) begin
			busy_q <= 1'b1;
		end else if (tok[MAX_VERTICES].valid) begin
			busy_q <= 1'b0;
		end
	end

	// Final compare of the last edge and the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tok[MAX_VERTICES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[MAX_VERTICES].valid) begin
			inside_q <= !few &&
				(tok[MAX_VERTICES].parity ^ edge_cross(tok[MAX_VERTICES]));
			few_q    <= few;
			drop_q   <= ovf_q;
		end
	end

	assign busy             = busy_q;
	assign done             = done_q;
	assign inside_res       = inside_q;
	assign too_few_vertices = few_q;
	assign vertices_dropped = drop_q;

	// At most one test token is in the row at any time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one test token in the cell row");

	// An accepted test raises busy.
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		tst |=> busy_q)
		else $error("busy not raised after a test beat");

	// A result beat never coincides with busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result beat while still busy");

	// Result strobe lasts a single cycle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe longer than one cycle");

	// The vertex count never exceeds the store size.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

endmodule
